/* src/bwst_pkg.sv */
// Shared types, codes and wait tables for the bus wait-state timing block.
`timescale 1ns / 1ps
`default_nettype none

package bwst_pkg;

  localparam int unsigned CfgW   = 15;
  localparam int unsigned CostW  = 4;
  localparam int unsigned CycW   = 5;
  localparam int unsigned BoundW = 17;

  localparam logic [CfgW-1:0] WaitCtrlMask = 15'h5FFF;

  localparam logic [1:0] WidthWord = 2'd2;

  typedef enum logic [2:0] {
    RegionOther,
    RegionWram,
    RegionVideo,
    RegionPak,
    RegionSram
  } region_e;

  typedef enum logic [1:0] {
    Window0,
    Window1,
    Window2
  } window_e;

  // Decoded access, carried from the decode stage to the cost stage
  typedef struct packed {
    region_e region;
    window_e window;
    logic    word;
    logic    seq;
    logic    edge_first;
    logic    edge_second;
  } dec_t;

  // First-access and second-access cost of one access
  typedef struct packed {
    logic [CostW-1:0] first;
    logic [CostW-1:0] second;
  } cost_t;

  function automatic logic [CostW-1:0] first_wait(input logic [1:0] idx);
    logic [CostW-1:0] w;
    unique case (idx)
      2'd0:    w = 4'd4;
      2'd1:    w = 4'd3;
      2'd2:    w = 4'd2;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  function automatic logic [CostW-1:0] second_wait(input window_e win, input logic sel);
    logic [CostW-1:0] w;
    if (sel) begin
      w = 4'd1;
    end else begin
      unique case (win)
        Window0: w = 4'd2;
        Window1: w = 4'd4;
        default: w = 4'd8;
      endcase
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/bwst_decode.sv */
// Decode stage: region, cartridge window and 128 KiB boundary flags.
`timescale 1ns / 1ps
`default_nettype none

module bwst_decode
  import bwst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] address_i,
  input  wire logic [1:0]  width_code_i,
  input  wire logic        is_sequential_i,
  output logic             valid_o,
  output dec_t             dec_o
);

  logic              valid_q;
  dec_t              dec_d, dec_q;
  logic [BoundW-1:0] base_lo;
  logic [BoundW-1:0] next_lo;
  logic              word;

  assign word = (width_code_i == WidthWord);

  always_comb begin
    base_lo = word ? {address_i[BoundW-1:2], 2'b00} : {address_i[BoundW-1:1], 1'b0};
    next_lo = base_lo + BoundW'(2);

    dec_d.word        = word;
    dec_d.seq         = is_sequential_i;
    dec_d.edge_first  = (base_lo == '0);
    dec_d.edge_second = (next_lo == '0);
    dec_d.window      = Window0;

    unique case (address_i[31:24])
      8'h02:         dec_d.region = RegionWram;
      8'h05, 8'h06:  dec_d.region = RegionVideo;
      8'h08, 8'h09:  dec_d.region = RegionPak;
      8'h0A, 8'h0B: begin
        dec_d.region = RegionPak;
        dec_d.window = Window1;
      end
      8'h0C, 8'h0D: begin
        dec_d.region = RegionPak;
        dec_d.window = Window2;
      end
      8'h0E, 8'h0F:  dec_d.region = RegionSram;
      default:       dec_d.region = RegionOther;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

/* src/bwst_cost.sv */
// Cost stage: look up first and second access costs from the wait control word.
`timescale 1ns / 1ps
`default_nettype none

module bwst_cost
  import bwst_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire dec_t            dec_i,
  input  wire logic [CfgW-1:0] wait_ctrl_i,
  output logic                 valid_o,
  output cost_t                cost_o
);

  logic             valid_q;
  cost_t            cost_d, cost_q;
  logic [1:0]       first_sel;
  logic             second_sel;
  logic [CostW-1:0] n_cost;
  logic [CostW-1:0] s_cost;

  always_comb begin
    unique case (dec_i.window)
      Window0: begin
        first_sel  = wait_ctrl_i[3:2];
        second_sel = wait_ctrl_i[4];
      end
      Window1: begin
        first_sel  = wait_ctrl_i[6:5];
        second_sel = wait_ctrl_i[7];
      end
      default: begin
        first_sel  = wait_ctrl_i[9:8];
        second_sel = wait_ctrl_i[10];
      end
    endcase
    n_cost = CostW'(1) + first_wait(first_sel);
    s_cost = CostW'(1) + second_wait(dec_i.window, second_sel);
  end

  always_comb begin
    cost_d.second = '0;
    unique case (dec_i.region)
      RegionWram: cost_d.first = dec_i.word ? 4'd6 : 4'd3;
      RegionVideo: cost_d.first = dec_i.word ? 4'd2 : 4'd1;
      RegionPak: begin
        // A boundary forces the beat to be non-sequential
        cost_d.first = (dec_i.seq && !dec_i.edge_first) ? s_cost : n_cost;
        if (dec_i.word) begin
          cost_d.second = dec_i.edge_second ? n_cost : s_cost;
        end
      end
      RegionSram: cost_d.first = CostW'(1) + first_wait(wait_ctrl_i[1:0]);
      default:    cost_d.first = 4'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cost_q <= cost_d;
    end
  end

  assign valid_o = valid_q;
  assign cost_o  = cost_q;

endmodule

`default_nettype wire

/* src/bus_wait_state_timing.sv */
// Top level of the bus wait-state timing block: config register and sum stage.
//
// Usage: drive address_i, width_code_i and is_sequential_i with start high for
// one cycle per access. busy stays low, so an access may be issued in every
// cycle. Each access yields exactly one beat on cycles_o, marked by done_o
// for a single cycle, once it has passed the registered stages in order: decode,
// cost lookup, then the final add of the two halfword costs.
// Throughput is one access per cycle; the three register stages set the
// latency.
// Write the wait control word through cfg_we_i / cfg_wdata_i while no access
// is in flight; bits outside 0x5FFF are dropped.
// Reset clears the control word to zero and empties the pipeline. The
// receiver cannot stall: results are presented once and must be taken.
`timescale 1ns / 1ps
`default_nettype none

module bus_wait_state_timing
  import bwst_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic [31:0]     address_i,
  input  wire logic [1:0]      width_code_i,
  input  wire logic            is_sequential_i,
  output logic [CycW-1:0]      cycles_o,
  output logic                 done_o
);

  logic [CfgW-1:0] wait_ctrl_q;
  logic            dec_valid;
  dec_t            dec;
  logic            cost_valid;
  cost_t           cost;
  logic            done_q;
  logic [CycW-1:0] cycles_d, cycles_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ctrl_q <= '0;
    end else if (cfg_we_i) begin
      wait_ctrl_q <= cfg_wdata_i & WaitCtrlMask;
    end
  end

  bwst_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start & ~busy),
    .address_i       (address_i),
    .width_code_i    (width_code_i),
    .is_sequential_i (is_sequential_i),
    .valid_o         (dec_valid),
    .dec_o           (dec)
  );

  bwst_cost u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dec_valid),
    .dec_i       (dec),
    .wait_ctrl_i (wait_ctrl_q),
    .valid_o     (cost_valid),
    .cost_o      (cost)
  );

  assign cycles_d = CycW'(cost.first) + CycW'(cost.second);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cost_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cost_valid) begin
      cycles_q <= cycles_d;
    end
  end

  assign done_o   = done_q;
  assign cycles_o = cycles_q;

endmodule

`default_nettype wire
